[rtl/pesd_pkg.sv]
// shared types, constants and helpers for the pes packet depacketizer
// no dependencies; used by pesd_parser and the top level
`default_nettype none

package pesd_pkg;

    localparam int unsigned POS_W = 17;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned OFF_W = 9;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // byte positions inside the fixed part of the header
    localparam logic [POS_W-1:0] POS_PREFIX0 = 17'd0;
    localparam logic [POS_W-1:0] POS_PREFIX1 = 17'd1;
    localparam logic [POS_W-1:0] POS_PREFIX2 = 17'd2;
    localparam logic [POS_W-1:0] POS_STREAM  = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd5;
    localparam logic [POS_W-1:0] POS_HDR_LEN = 17'd8;

    localparam logic [POS_W-1:0] BASE_HDR_BYTES = 17'd6;
    localparam logic [OFF_W-1:0] OFF_NO_HDR     = 9'd6;
    localparam logic [OFF_W-1:0] OFF_WITH_HDR   = 9'd9;

    localparam logic [23:0] PREFIX_CODE = 24'h000001;
    localparam logic [7:0]  MIN_STREAM  = 8'hBC;

    typedef enum logic
    {
        PHASE_IDLE,
        PHASE_ACTIVE
    } phase_t;

    typedef struct packed
    {
        logic       valid;
        logic [7:0] payload_byte;
        logic [7:0] stream_code;
        logic       first_in_packet;
        logic       last_in_packet;
        logic       length_unbounded;
    } result_t;

    // ids that carry no optional pes header
    function automatic logic id_has_no_header(input logic [7:0] id);
        return id == 8'hBC || id == 8'hBE || id == 8'hBF || id == 8'hF0 ||
               id == 8'hF1 || id == 8'hF2 || id == 8'hF8 || id == 8'hFF;
    endfunction

endpackage

`default_nettype wire

[rtl/pes_packet_depacketizer_core.sv]
// a payload byte appears on the output in the cycle after its input transaction
// one byte per cycle barring output stalls; one parse step ahead of the output register
// the input stays ready while the output register is empty or being drained
// header bytes, dropped packets and bytes past the declared end give no output
// reset (asynchronous, active low) returns the parser to idle and empties the output
// top level of the pes packet depacketizer; depends on pesd_pkg and pesd_parser
`default_nettype none

module pes_packet_depacketizer_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] unit_start
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output      logic [9:0]  m_axis_tuser,   // [7:0] stream_code, [8] first_in_packet,
                                             // [9] length_unbounded
    output      logic        m_axis_tlast    // last_in_packet
);

    pesd_pkg::result_t res;
    logic              s_accept;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg;
    logic [9:0]        out_user_reg;
    logic              out_last_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    pesd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s_accept),
        .data_byte  (s_axis_tdata),
        .unit_start (s_axis_tuser),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_accept)
            out_valid_next = res.valid;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload side of the output register, loaded only with a real result
    always_ff @(posedge clk)
    begin
        if (s_accept && res.valid)
        begin
            out_data_reg <= res.payload_byte;
            out_user_reg <= {res.length_unbounded, res.first_in_packet, res.stream_code};
            out_last_reg <= res.last_in_packet;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/pesd_parser.sv]
// per-packet parse state and the decision for one byte
// depends on pesd_pkg
`default_nettype none

module pesd_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              unit_start,
    output pesd_pkg::result_t      res
);

    pesd_pkg::phase_t                 phase_reg, phase_next;
    logic [pesd_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]                       stream_reg, stream_next;
    logic [pesd_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [pesd_pkg::OFF_W-1:0]       off_reg, off_next;
    logic                             first_reg, first_next;

    pesd_pkg::phase_t                 eff_phase;
    logic [pesd_pkg::POS_W-1:0]       eff_pos;
    logic [7:0]                       eff_stream;
    logic [pesd_pkg::LEN_W-1:0]       eff_len;
    logic [pesd_pkg::OFF_W-1:0]       eff_off;
    logic                             eff_first;
    logic                             bounded;
    logic [pesd_pkg::POS_W-1:0]       end_pos;
    logic                             is_last;
    logic                             emit;

    always_comb
    begin
        // a packet start resets the context before the byte is examined
        eff_phase  = unit_start ? pesd_pkg::PHASE_ACTIVE : phase_reg;
        eff_pos    = unit_start ? '0 : pos_reg;
        eff_stream = unit_start ? '0 : stream_reg;
        eff_len    = unit_start ? '0 : len_reg;
        eff_off    = unit_start ? pesd_pkg::OFF_NO_HDR : off_reg;
        eff_first  = unit_start ? 1'b1 : first_reg;

        phase_next  = eff_phase;
        pos_next    = eff_pos;
        stream_next = eff_stream;
        len_next    = eff_len;
        off_next    = eff_off;
        first_next  = eff_first;

        bounded = eff_len != '0;
        end_pos = pesd_pkg::BASE_HDR_BYTES + {1'b0, eff_len};
        is_last = bounded && (eff_pos + 17'd1 == end_pos);
        emit    = 1'b0;

        if (eff_phase == pesd_pkg::PHASE_ACTIVE)
        begin
            if (eff_pos != pesd_pkg::POS_MAX)
            begin
                pos_next = eff_pos + 17'd1;
            end
            case (eff_pos)
                pesd_pkg::POS_PREFIX0:
                begin
                    if (data_byte != pesd_pkg::PREFIX_CODE[23:16])
                        phase_next = pesd_pkg::PHASE_IDLE;
                end
                pesd_pkg::POS_PREFIX1:
                begin
                    if (data_byte != pesd_pkg::PREFIX_CODE[15:8])
                        phase_next = pesd_pkg::PHASE_IDLE;
                end
                pesd_pkg::POS_PREFIX2:
                begin
                    if (data_byte != pesd_pkg::PREFIX_CODE[7:0])
                        phase_next = pesd_pkg::PHASE_IDLE;
                end
                pesd_pkg::POS_STREAM:
                begin
                    if (data_byte < pesd_pkg::MIN_STREAM)
                    begin
                        phase_next = pesd_pkg::PHASE_IDLE;
                    end
                    else
                    begin
                        stream_next = data_byte;
                        off_next    = pesd_pkg::id_has_no_header(data_byte)
                                    ? pesd_pkg::OFF_NO_HDR : pesd_pkg::OFF_WITH_HDR;
                    end
                end
                pesd_pkg::POS_LEN_HI:
                begin
                    len_next = {data_byte, 8'h00};
                end
                pesd_pkg::POS_LEN_LO:
                begin
                    len_next = {eff_len[15:8], data_byte};
                end
                default:
                begin
                    if (bounded && eff_pos >= end_pos)
                    begin
                        phase_next = pesd_pkg::PHASE_IDLE;
                    end
                    else if (eff_pos == pesd_pkg::POS_HDR_LEN &&
                             !pesd_pkg::id_has_no_header(eff_stream))
                    begin
                        off_next = pesd_pkg::OFF_WITH_HDR + {1'b0, data_byte};
                    end
                    else if (eff_pos >= {8'd0, eff_off})
                    begin
                        emit       = 1'b1;
                        first_next = 1'b0;
                        if (is_last)
                            phase_next = pesd_pkg::PHASE_IDLE;
                    end
                end
            endcase
        end

        res.valid            = step && emit;
        res.payload_byte     = data_byte;
        res.stream_code      = eff_stream;
        res.first_in_packet  = eff_first;
        res.last_in_packet   = is_last;
        res.length_unbounded = !bounded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pesd_pkg::PHASE_IDLE;
            pos_reg    <= '0;
            stream_reg <= '0;
            len_reg    <= '0;
            off_reg    <= pesd_pkg::OFF_NO_HDR;
            first_reg  <= 1'b1;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            stream_reg <= stream_next;
            len_reg    <= len_next;
            off_reg    <= off_next;
            first_reg  <= first_next;
        end
    end

endmodule

`default_nettype wire

[rtl/pesd_checker.sv]
// port-level checks for the pes packet depacketizer core
// bound to pes_packet_depacketizer_core; no package dependency
`default_nettype none

module pesd_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [9:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled output transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction withdrawn while stalled");

    // input must not stall while the output register is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // an unbounded packet never carries a last mark
    a_unbounded_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[9] |-> !m_axis_tlast)
        else $error("last mark on unbounded packet");

    // only stream ids at or above the lowest valid id reach the output
    a_stream_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[7:0] >= 8'hBC)
        else $error("payload from a stream id below the valid range");

endmodule

bind pes_packet_depacketizer_core pesd_checker u_pesd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/tb_pes_packet_depacketizer_core.sv]
// self-checking testbench for pes_packet_depacketizer_core: streams pes packets through the core
// and checks every payload transaction against an in-bench parser model
// depends on pesd_pkg and the core rtl only
module tb_pes_packet_depacketizer_core;

    // stream ids that carry no optional pes header
    localparam logic [7:0] BARE_IDS [8] = '{8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8,
                                            8'hFF};
    localparam logic [7:0] VIDEO_ID = 8'hE0;
    localparam int RANDOM_BYTES = 1000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed
    {
        logic [7:0] data;
        logic       start;
        logic       rush;
    } pes_byte_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic [7:0] stream;
        logic       first;
        logic       last;
        logic       unbounded;
    } es_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [9:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        rush_mode = 1'b0;

    pes_byte_t stream_bytes [$];
    es_byte_t  es_bytes_due [$];

    int bytes_taken = 0;
    int mismatches = 0;
    int send_gap = 0;
    int drv_calm_left = 0;
    bit drv_calm = 1'b0;
    int hold_left = 0;
    int snk_calm_left = 0;
    bit snk_calm = 1'b0;

    // parser model state
    pesd_pkg::phase_t           parse_state = pesd_pkg::PHASE_IDLE;
    logic [pesd_pkg::POS_W-1:0] next_pos = '0;
    logic [7:0]                 cur_stream = '0;
    logic [pesd_pkg::LEN_W-1:0] decl_len = '0;
    logic [pesd_pkg::OFF_W-1:0] pay_off = pesd_pkg::OFF_NO_HDR;
    logic                       first_due = 1'b1;

    pes_packet_depacketizer_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic bit bare_stream(input logic [7:0] id);
        foreach (BARE_IDS[i])
        begin
            if (BARE_IDS[i] == id)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // one parse step; queues the payload byte it yields, if any
    task automatic parse_byte(input logic [7:0] b, input logic start);
        logic [pesd_pkg::POS_W-1:0] pos;
        logic [pesd_pkg::POS_W:0]   pkt_end;
        logic                       bounded;
        es_byte_t                   exp;
        if (start)
        begin
            parse_state = pesd_pkg::PHASE_ACTIVE;
            next_pos = '0;
            cur_stream = '0;
            decl_len = '0;
            pay_off = pesd_pkg::OFF_NO_HDR;
            first_due = 1'b1;
        end
        if (parse_state != pesd_pkg::PHASE_ACTIVE)
            return;
        pos = next_pos;
        if (next_pos != pesd_pkg::POS_MAX)
            next_pos = next_pos + 1'b1;
        bounded = decl_len != '0;
        pkt_end = {1'b0, pesd_pkg::BASE_HDR_BYTES} + (pesd_pkg::POS_W+1)'(decl_len);
        if (pos == pesd_pkg::POS_PREFIX0)
        begin
            if (b != pesd_pkg::PREFIX_CODE[23:16])
                parse_state = pesd_pkg::PHASE_IDLE;
        end
        else if (pos == pesd_pkg::POS_PREFIX1)
        begin
            if (b != pesd_pkg::PREFIX_CODE[15:8])
                parse_state = pesd_pkg::PHASE_IDLE;
        end
        else if (pos == pesd_pkg::POS_PREFIX2)
        begin
            if (b != pesd_pkg::PREFIX_CODE[7:0])
                parse_state = pesd_pkg::PHASE_IDLE;
        end
        else if (pos == pesd_pkg::POS_STREAM)
        begin
            if (b < pesd_pkg::MIN_STREAM)
                parse_state = pesd_pkg::PHASE_IDLE;
            else
            begin
                cur_stream = b;
                pay_off = bare_stream(b) ? pesd_pkg::OFF_NO_HDR : pesd_pkg::OFF_WITH_HDR;
            end
        end
        else if (pos == pesd_pkg::POS_LEN_HI)
            decl_len[15:8] = b;
        else if (pos == pesd_pkg::POS_LEN_LO)
            decl_len[7:0] = b;
        else if (bounded && {1'b0, pos} >= pkt_end)
            parse_state = pesd_pkg::PHASE_IDLE;
        else if (pos == pesd_pkg::POS_HDR_LEN && !bare_stream(cur_stream))
            pay_off = pesd_pkg::OFF_WITH_HDR + {1'b0, b};
        else if (pos >= pay_off)
        begin
            exp.data = b;
            exp.stream = cur_stream;
            exp.first = first_due;
            exp.last = bounded && ({1'b0, pos} + 1'b1 == pkt_end);
            exp.unbounded = !bounded;
            es_bytes_due.insert(es_bytes_due.size(), exp);
            first_due = 1'b0;
            if (exp.last)
                parse_state = pesd_pkg::PHASE_IDLE;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start, input logic rush);
        stream_bytes.insert(stream_bytes.size(), {b, start, rush});
    endtask

    // start code, stream id, length, then n_after bytes; byte 8 carries hdr_len where it applies
    task automatic push_packet(input logic [7:0] id, input logic [15:0] len,
                               input logic [7:0] hdr_len, input int n_after, input logic rush);
        push_byte(pesd_pkg::PREFIX_CODE[23:16], 1'b1, rush);
        push_byte(pesd_pkg::PREFIX_CODE[15:8], 1'b0, rush);
        push_byte(pesd_pkg::PREFIX_CODE[7:0], 1'b0, rush);
        push_byte(id, 1'b0, rush);
        push_byte(len[15:8], 1'b0, rush);
        push_byte(len[7:0], 1'b0, rush);
        for (int k = 0; k < n_after; k++)
        begin
            if (k + 6 == int'(pesd_pkg::POS_HDR_LEN) && !bare_stream(id))
                push_byte(hdr_len, 1'b0, rush);
            else
                push_byte(8'($urandom), 1'b0, rush);
        end
    endtask

    function automatic logic [7:0] pick_stream(input bit bare);
        logic [7:0] id;
        if (bare)
            return BARE_IDS[$urandom_range(0, 7)];
        do
            id = 8'($urandom_range(pesd_pkg::MIN_STREAM, 8'hFF));
        while (bare_stream(id));
        return id;
    endfunction

    // driver
    always @(posedge clk)
    begin
        pes_byte_t cur;
        if (rst_n)
        begin
            if (drv_calm_left == 0)
            begin
                drv_calm = $urandom_range(0, 3) == 0;
                drv_calm_left = $urandom_range(20, 200);
            end
            else
                drv_calm_left--;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 || stream_bytes.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    cur = stream_bytes[0];
                    stream_bytes.delete(0);
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= cur.data;
                    s_axis_tuser <= cur.start;
                    rush_mode <= cur.rush;
                    send_gap = (cur.rush || drv_calm || $urandom_range(0, 1)) ? 0 : pick_gap();
                end
            end
        end
    end

    // sink back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (snk_calm_left == 0)
            begin
                snk_calm = $urandom_range(0, 3) == 0;
                snk_calm_left = $urandom_range(20, 200);
            end
            else
                snk_calm_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rush_mode ? $urandom_range(0, 15) == 0
                               : !snk_calm && $urandom_range(0, 3) == 0)
            begin
                hold_left = rush_mode ? 0 : pick_gap() - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor: model each accepted byte, then check each payload transaction
    always @(posedge clk)
    begin
        es_byte_t exp;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                bytes_taken++;
                parse_byte(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (es_bytes_due.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected payload transaction, payload_byte %0h", m_axis_tdata);
                end
                else
                begin
                    exp = es_bytes_due[0];
                    es_bytes_due.delete(0);
                    if (m_axis_tdata !== exp.data)
                    begin
                        mismatches++;
                        $error("payload_byte expected %0h got %0h", exp.data, m_axis_tdata);
                    end
                    if (m_axis_tuser[7:0] !== exp.stream)
                    begin
                        mismatches++;
                        $error("stream_code expected %0h got %0h", exp.stream,
                               m_axis_tuser[7:0]);
                    end
                    if (m_axis_tuser[8] !== exp.first)
                    begin
                        mismatches++;
                        $error("first_in_packet expected %0b got %0b", exp.first, m_axis_tuser[8]);
                    end
                    if (m_axis_tlast !== exp.last)
                    begin
                        mismatches++;
                        $error("last_in_packet expected %0b got %0b", exp.last, m_axis_tlast);
                    end
                    if (m_axis_tuser[9] !== exp.unbounded)
                    begin
                        mismatches++;
                        $error("length_unbounded expected %0b got %0b", exp.unbounded,
                               m_axis_tuser[9]);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [8:0]  opening [25];
        logic [7:0]  id;
        logic [7:0]  hdr_len;
        logic [15:0] len;
        int          n_pay;
        int          n_after;
        int          noise_bytes;
        int          bad_at;
        int          total;
        int          kind;
        bit          bare;

        // bit 8 marks a packet start
        opening = '{9'h080,                                   // stray byte while idle
                    9'h100, 9'h000, 9'h001, 9'h0BC, 9'h000, 9'h002, 9'h000, 9'h0FF,
                    9'h07E,                                   // byte past the declared end
                    9'h100, 9'h000, 9'h001, 9'h0FF, 9'h000, 9'h000, 9'h012, 9'h034,
                    9'h100, 9'h000, 9'h001, 9'h0BB, 9'h05A,   // abandons the open packet
                    9'h100, 9'h001};                          // broken start code
        foreach (opening[i])
            push_byte(opening[i][7:0], opening[i][8], 1'b0);

        noise_bytes = 0;
        while (stream_bytes.size() - noise_bytes < RANDOM_BYTES + 25)
        begin
            kind = $urandom_range(0, 99);
            bare = $urandom_range(0, 1);
            id = pick_stream(bare);
            hdr_len = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            n_pay = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12);
            if (kind < 55)
            begin
                // well-formed, sometimes trailed by bytes past its end
                len = bare ? 16'(n_pay) : 16'(3 + hdr_len + n_pay);
                if (len == 0)
                    len = 1;
                n_after = len + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
                push_packet(id, len, hdr_len, n_after, 1'b0);
            end
            else if (kind < 65)
                push_packet(id, 16'd0, hdr_len, $urandom_range(0, 15), 1'b0);
            else if (kind < 75)
            begin
                // cut short by the next start
                len = 16'($urandom_range(1, 16'hFFFF));
                n_after = $urandom_range(0, (len > 12) ? 12 : len - 1);
                push_packet(id, len, hdr_len, n_after, 1'b0);
            end
            else if (kind < 83)
            begin
                // length ends inside the optional header
                id = pick_stream(1'b0);
                len = 16'($urandom_range(1, 3 + hdr_len));
                push_packet(id, len, hdr_len, len + $urandom_range(0, 3), 1'b0);
            end
            else if (kind < 91)
            begin
                bad_at = $urandom_range(0, 2);
                for (int k = 0; k <= bad_at; k++)
                begin
                    if (k < bad_at)
                        push_byte(pesd_pkg::PREFIX_CODE[23-8*k -: 8], k == 0, 1'b0);
                    else if (k == 2)
                        push_byte(pesd_pkg::PREFIX_CODE[7:0] ^ 8'($urandom_range(1, 255)),
                                  1'b0, 1'b0);
                    else
                        push_byte(8'($urandom_range(1, 255)), k == 0, 1'b0);
                end
                for (int k = $urandom_range(0, 4); k > 0; k--)
                    push_byte(8'($urandom), 1'b0, 1'b0);
            end
            else if (kind < 96)
                push_packet(8'($urandom_range(0, pesd_pkg::MIN_STREAM - 1)), 16'($urandom),
                            hdr_len, $urandom_range(0, 4), 1'b0);
            else
            begin
                n_after = $urandom_range(1, 4);
                noise_bytes += n_after;
                for (int k = 0; k < n_after; k++)
                    push_byte(8'($urandom), 1'b0, 1'b0);
            end
        end

        // unbounded packet streamed at full rate, then a normal one
        push_packet(VIDEO_ID, 16'd0, 8'd0, 40, 1'b1);
        push_packet(BARE_IDS[0], 16'd4, 8'd0, 4, 1'b0);

        total = stream_bytes.size();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (bytes_taken < total || es_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && es_bytes_due.size() == 0)
            $display("pes_packet_depacketizer_core verification clean");
        else
            $display("pes_packet_depacketizer_core verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("pes_packet_depacketizer_core verification failed");
        $finish;
    end

endmodule
